FILE: design/assert_macros.svh
// Assertion macros of the subpicture RLE decoder, used by the back stage
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define SRD_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle
`define SRD_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle
`define SRD_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/srd_pkg.sv
// Package with types and constants of the subpicture RLE decoder
`timescale 1ns / 1ps

package srd_pkg;

	// Port widths
	localparam int DATA_W        = 8;
	localparam int LINE_WIDTH_W  = 13;
	localparam int FIELD_LINES_W = 12;
	localparam int COLOR_W       = 2;
	localparam int RUN_LEN_W     = 13;
	localparam int START_COL_W   = 12;
	localparam int LINE_IDX_W    = 11;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = LINE_WIDTH_W;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_LINES = 1'd1;

	// Register reset values
	localparam int LINE_WIDTH_RST  = 720;
	localparam int FIELD_LINES_RST = 240;

	// Default size limits
	localparam int DEF_MAX_WIDTH = 4096;
	localparam int DEF_MAX_LINES = 2048;

	// Code growth thresholds after one, two and three nibbles
	localparam int CODE_LIM_1 = 'h4;
	localparam int CODE_LIM_2 = 'h10;
	localparam int CODE_LIM_3 = 'h040;
	localparam int ACC_W      = 6;
	localparam int CODE_W     = ACC_W + 4;

	// Byte queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// One classified stream byte
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              first;
		logic              last;
		logic              hi_short;   // high nibble below the first threshold
		logic              lo_short;   // low nibble below the first threshold
	} srd_byte_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic nonempty;
	} srd_q_status_t;

	// One decoded run
	typedef struct packed {
		logic [COLOR_W-1:0]     pixel_color;
		logic [RUN_LEN_W-1:0]   run_length;
		logic [START_COL_W-1:0] start_column;
		logic [LINE_IDX_W-1:0]  line_index;
		logic                   line_end;
		logic                   field_done;
		logic                   stream_error;
		logic                   last_of_byte;
	} srd_result_t;

endpackage

FILE: design/srd_front.sv
// Front stage: accept stream bytes and classify their nibbles
`timescale 1ns / 1ps

module srd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [srd_pkg::DATA_W-1:0]  data_byte,
	input  logic                        first_byte,
	input  logic                        last_byte,
	input  srd_pkg::srd_q_status_t      q_status,
	output logic                        push,
	output srd_pkg::srd_byte_t          push_data
);
	import srd_pkg::*;

	logic      valid_s1;
	srd_byte_t byte_s1;
	srd_byte_t byte_in;

	// Classify both nibbles against the first growth threshold
	always_comb begin
		byte_in.data     = data_byte;
		byte_in.first    = first_byte;
		byte_in.last     = last_byte;
		byte_in.hi_short = (data_byte[7:4] < 4'(CODE_LIM_1));
		byte_in.lo_short = (data_byte[3:0] < 4'(CODE_LIM_1));
	end

	// Hold the stage while the queue is full
	assign in_stall  = valid_s1 && q_status.full;
	assign push      = valid_s1 && !q_status.full;
	assign push_data = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= byte_in;
		end
	end

endmodule

FILE: design/srd_queue.sv
// Short byte queue between the front and back stages
`timescale 1ns / 1ps

module srd_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  srd_pkg::srd_byte_t      push_data,
	input  logic                    pop,
	output srd_pkg::srd_q_status_t  status,
	output srd_pkg::srd_byte_t      head
);
	import srd_pkg::*;

	srd_byte_t           slots_q [Q_DEPTH];
	logic [Q_AW-1:0]     wr_ptr_q;
	logic [Q_AW-1:0]     rd_ptr_q;
	logic [Q_CW-1:0]     count_q;

	assign status.full     = (count_q == Q_CW'(Q_DEPTH));
	assign status.nonempty = (count_q != '0);
	assign head            = slots_q[rd_ptr_q];

	// Write the pushed beat
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: design/srd_back.sv
// Back stage: decode both nibbles of a byte into runs and hold results
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srd_back #(
	parameter int MAX_WIDTH = srd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_LINES = srd_pkg::DEF_MAX_LINES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [srd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  srd_pkg::srd_q_status_t         q_status,
	input  srd_pkg::srd_byte_t             head,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output srd_pkg::srd_result_t           out_res
);
	import srd_pkg::*;

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int LW    = $clog2(MAX_LINES + 1);
	localparam int CW    = (WW > 8) ? WW : 8;
	localparam int W_RST = (LINE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : LINE_WIDTH_RST;
	localparam int H_RST = (FIELD_LINES_RST > MAX_LINES) ? MAX_LINES : FIELD_LINES_RST;

	// Outcome of one nibble
	typedef struct packed {
		logic              complete;
		logic [ACC_W-1:0]  acc_n;
		logic [1:0]        held_n;
		logic [COLOR_W-1:0] color;
		logic [WW-1:0]     len;
		logic              le;
	} step_t;

	// Add one nibble to the partial code and size the run against the line rest
	function automatic step_t nib_step(input logic [ACC_W-1:0] acc, input logic [1:0] held,
			input logic [3:0] nib, input logic is_short, input logic [WW-1:0] rem);
		logic [CODE_W-1:0] v;
		logic              done;
		logic              fill;
		logic [CW-1:0]     raw_e;
		logic [CW-1:0]     rem_e;
		step_t             s;
		v = {acc, nib};
		unique case (held)
			2'd0:    done = !is_short;
			2'd1:    done = (v >= CODE_W'(CODE_LIM_2));
			2'd2:    done = (v >= CODE_W'(CODE_LIM_3));
			default: done = 1'b1;
		endcase
		fill    = (held == 2'd3) && (acc == '0) && is_short;
		raw_e   = CW'(v[CODE_W-1:2]);
		rem_e   = CW'(rem);
		s.color = v[COLOR_W-1:0];
		s.complete = done;
		if (done) begin
			s.acc_n  = '0;
			s.held_n = 2'd0;
			if (fill || raw_e >= rem_e) begin
				s.len = rem;
				s.le  = 1'b1;
			end else begin
				s.len = WW'(raw_e);
				s.le  = 1'b0;
			end
		end else begin
			s.acc_n  = v[ACC_W-1:0];
			s.held_n = held + 2'd1;
			s.len    = '0;
			s.le     = 1'b0;
		end
		return s;
	endfunction

	// Configuration and decode state
	logic [WW-1:0]    w_q;
	logic [LW-1:0]    h_q;
	logic [ACC_W-1:0] acc_q;
	logic [1:0]       held_q;
	logic [WW-1:0]    col_q;
	logic [LW-1:0]    line_q;
	logic             halted_q;

	// Output register and second-run holding register
	logic             out_valid_q;
	srd_result_t      out_res_q;
	logic             pend_valid_q;
	srd_result_t      pend_res_q;

	// Decode signals
	logic [ACC_W-1:0] acc0;
	logic [1:0]       held0;
	logic [WW-1:0]    col0;
	logic [LW-1:0]    line0;
	logic             halt0;
	logic [WW-1:0]    rem0;
	logic [WW-1:0]    rem1;
	logic [WW-1:0]    col_a;
	logic [WW-1:0]    col_b;
	logic [WW-1:0]    col_end;
	logic             last_line;
	step_t            s0;
	step_t            s1;
	logic             r0_valid;
	logic             r1_valid;
	logic             r0_le;
	logic             r1_le;
	logic             ev_le;
	logic             fd;
	logic             err_flag;
	logic             two;
	logic             any_res;
	srd_result_t      res0;
	srd_result_t      res1;
	srd_result_t      res_a;
	srd_result_t      res_b;
	logic [ACC_W-1:0] acc_nx;
	logic [1:0]       held_nx;
	logic [WW-1:0]    col_nx;
	logic [LW-1:0]    line_nx;
	logic             halted_nx;
	logic             slot_free;
	logic             out_take;

	logic [31:0]      w_wr;
	logic [31:0]      h_wr;

	// Restart on first byte, then walk both nibbles of the head byte
	always_comb begin
		acc0  = head.first ? '0 : acc_q;
		held0 = head.first ? 2'd0 : held_q;
		col0  = head.first ? '0 : col_q;
		line0 = head.first ? '0 : line_q;
		halt0 = head.first ? 1'b0 : halted_q;

		rem0      = (col0 < w_q) ? (w_q - col0) : '0;
		last_line = ((LW + 1)'(line0) + 1'b1) >= (LW + 1)'(h_q);

		s0       = nib_step(acc0, held0, head.data[7:4], head.hi_short, rem0);
		r0_valid = !halt0 && s0.complete;
		r0_le    = r0_valid && s0.le;
		col_a    = col0 + s0.len;
		rem1     = rem0 - s0.len;

		s1       = nib_step(s0.acc_n, s0.held_n, head.data[3:0], head.lo_short, rem1);
		r1_valid = !halt0 && !r0_le && s1.complete;
		r1_le    = r1_valid && s1.le;
		col_b    = col_a + s1.len;

		ev_le    = r0_le || r1_le;
		fd       = ev_le && last_line;
		col_end  = r0_le ? col_a : col_b;
		err_flag = head.last && !halt0 && !fd;
		two      = r0_valid && r1_valid;
		any_res  = r0_valid || r1_valid || err_flag;

		// Runs as they leave each nibble
		res0.pixel_color  = s0.color;
		res0.run_length   = RUN_LEN_W'(s0.len);
		res0.start_column = START_COL_W'(col0);
		res0.line_index   = LINE_IDX_W'(line0);
		res0.line_end     = s0.le;
		res0.field_done   = r0_le && last_line;
		res0.stream_error = 1'b0;
		res0.last_of_byte = 1'b0;

		res1.pixel_color  = s1.color;
		res1.run_length   = RUN_LEN_W'(s1.len);
		res1.start_column = START_COL_W'(col_a);
		res1.line_index   = LINE_IDX_W'(line0);
		res1.line_end     = s1.le;
		res1.field_done   = r1_le && last_line;
		res1.stream_error = 1'b0;
		res1.last_of_byte = 1'b0;

		// Pick the first beat; an empty byte at stream end gives an error-only beat
		if (r0_valid) begin
			res_a = res0;
		end else if (r1_valid) begin
			res_a = res1;
		end else begin
			res_a              = '0;
			res_a.start_column = START_COL_W'(col0);
			res_a.line_index   = LINE_IDX_W'(line0);
		end
		res_a.stream_error = err_flag && !two;
		res_a.last_of_byte = !two;
		res_b              = res1;
		res_b.stream_error = err_flag;
		res_b.last_of_byte = 1'b1;

		// Next decode state
		if (halt0) begin
			acc_nx    = acc0;
			held_nx   = held0;
			col_nx    = col0;
			line_nx   = line0;
			halted_nx = 1'b1;
		end else begin
			acc_nx    = r0_le ? '0 : s1.acc_n;
			held_nx   = r0_le ? 2'd0 : s1.held_n;
			col_nx    = ev_le ? (fd ? col_end : '0) : col_b;
			line_nx   = (ev_le && !fd) ? line0 + 1'b1 : line0;
			halted_nx = fd || head.last;
		end
	end

	// Pop a byte once its beats have room; bytes without beats pass at once
	assign out_take  = out_valid_q && !out_stall;
	assign slot_free = !out_valid_q || out_take;
	assign pop       = !pend_valid_q && q_status.nonempty && (slot_free || !any_res);

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// Clamp configuration writes to the supported sizes
	assign w_wr = 32'(cfg_data[LINE_WIDTH_W-1:0]);
	assign h_wr = 32'(cfg_data[FIELD_LINES_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(W_RST);
			h_q <= LW'(H_RST);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_LINE_WIDTH:  w_q <= (w_wr > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_wr);
				CFG_FIELD_LINES: h_q <= (h_wr > 32'(MAX_LINES)) ? LW'(MAX_LINES) : LW'(h_wr);
				default: ;
			endcase
		end
	end

	// Advance decode state on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			held_q   <= 2'd0;
			col_q    <= '0;
			line_q   <= '0;
			halted_q <= 1'b0;
		end else if (pop) begin
			acc_q    <= acc_nx;
			held_q   <= held_nx;
			col_q    <= col_nx;
			line_q   <= line_nx;
			halted_q <= halted_nx;
		end
	end

	// Output beat sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (pend_valid_q) begin
			if (slot_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end
		end else if (pop && any_res) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= two;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_valid_q) begin
			if (slot_free) begin
				out_res_q <= pend_res_q;
			end
		end else if (pop && any_res) begin
			out_res_q  <= res_a;
			pend_res_q <= res_b;
		end
	end

	`SRD_IMPLY(a_pend_behind_out, pend_valid_q, out_valid_q && !out_res_q.last_of_byte,
		"held second run without an unfinished first beat in the output register")
	`SRD_IMPLY(a_done_ends_line, out_valid_q && out_res_q.field_done, out_res_q.line_end,
		"field done on a run that does not end its line")
	`SRD_IMPLY(a_partial_code, held_q != 2'd0, {1'b0, acc_q} < (ACC_W + 1)'(CODE_LIM_3),
		"partial code has grown past the last threshold")
	`SRD_NEXT(a_two_runs_hold, pop && two && !out_take && out_valid_q, 1'b0,
		"second run popped while the output register was busy")
	`SRD_IMPLY(a_empty_no_pop, !q_status.nonempty, !pop,
		"pop from an empty queue")

endmodule

FILE: design/subpicture_rle_decoder.sv
// Top level of the subpicture RLE field decoder
//
//   channel  direction  handshake              beat
//   in       sink       in_valid / in_stall    data_byte, first_byte, last_byte
//   out      source     out_valid / out_stall  one run with its line and column
//   cfg      sink       cfg_wr_en              cfg_index, cfg_data
//
// One byte per cycle unless stalled; a byte that yields two runs holds the
// decoder until its second run enters the single output register both leave by.
// Bytes pass the front register and a queue slot before the output register.
// Reset sets line_width to 720 and field_lines to 240 and clears the decode
// state; no clearing pass is needed.
// A stall on out backs up through the four-entry byte queue into in_stall.
`timescale 1ns / 1ps

module subpicture_rle_decoder #(
	parameter int MAX_WIDTH = srd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_LINES = srd_pkg::DEF_MAX_LINES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [srd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [srd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [srd_pkg::DATA_W-1:0]       data_byte,
	input  logic                             first_byte,
	input  logic                             last_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [srd_pkg::COLOR_W-1:0]      pixel_color,
	output logic [srd_pkg::RUN_LEN_W-1:0]    run_length,
	output logic [srd_pkg::START_COL_W-1:0]  start_column,
	output logic [srd_pkg::LINE_IDX_W-1:0]   line_index,
	output logic                             line_end,
	output logic                             field_done,
	output logic                             stream_error,
	output logic                             last_of_byte
);
	import srd_pkg::*;

	srd_q_status_t q_status;
	srd_byte_t     push_data;
	srd_byte_t     head;
	logic          push;
	logic          pop;
	srd_result_t   out_res;

	srd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.first_byte(first_byte),
		.last_byte (last_byte),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	srd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.status   (q_status),
		.head     (head)
	);

	srd_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_LINES(MAX_LINES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_status (q_status),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res  (out_res)
	);

	// Unpack the result beat onto its ports
	assign pixel_color  = out_res.pixel_color;
	assign run_length   = out_res.run_length;
	assign start_column = out_res.start_column;
	assign line_index   = out_res.line_index;
	assign line_end     = out_res.line_end;
	assign field_done   = out_res.field_done;
	assign stream_error = out_res.stream_error;
	assign last_of_byte = out_res.last_of_byte;

endmodule

FILE: dv/subpicture_rle_decoder_tb.sv
// Self-checking testbench of the subpicture RLE field decoder
`timescale 1ns / 1ps

module subpicture_rle_decoder_tb;
	import srd_pkg::*;

	localparam int MAX_W = DEF_MAX_WIDTH;
	localparam int MAX_L = DEF_MAX_LINES;
	localparam int PHASE_BYTES = 60;
	localparam int N_PHASES = 11;
	localparam int MAX_PRINTS = 60;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_RUN} row_kind_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              first;
		logic              last;
		row_kind_t         kind;
		srd_result_t       run;
	} stim_row_t;

	localparam srd_result_t NO_RUN = '0;
	localparam srd_result_t ERR_AT_ORIGIN = '{pixel_color: 2'd0, run_length: 13'd0,
		start_column: 12'd0, line_index: 11'd0, line_end: 1'b0, field_done: 1'b0,
		stream_error: 1'b1, last_of_byte: 1'b1};
	localparam srd_result_t ONE_PIXEL = '{pixel_color: 2'd0, run_length: 13'd1,
		start_column: 12'd0, line_index: 11'd0, line_end: 1'b0, field_done: 1'b0,
		stream_error: 1'b0, last_of_byte: 1'b1};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_LINE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic [DATA_W-1:0] data_byte = '0;
	logic first_byte = 1'b0;
	logic last_byte = 1'b0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic [COLOR_W-1:0] pixel_color;
	logic [RUN_LEN_W-1:0] run_length;
	logic [START_COL_W-1:0] start_column;
	logic [LINE_IDX_W-1:0] line_index;
	logic line_end, field_done, stream_error, last_of_byte;

	// Typed expectation travelling with the beat on the input side
	row_kind_t pin_kind = ROW_PREDICT;
	srd_result_t pin_run = '0;

	// Decoder shadow: configuration and decode state
	logic [LINE_WIDTH_W-1:0] lw_reg = LINE_WIDTH_W'(LINE_WIDTH_RST);
	logic [FIELD_LINES_W-1:0] fl_reg = FIELD_LINES_W'(FIELD_LINES_RST);
	logic [15:0] dec_acc = '0;
	int unsigned dec_held = 0;
	int unsigned dec_col = 0;
	int unsigned dec_line = 0;
	bit dec_halted = 1'b0;

	srd_result_t runs_due [$];
	logic [3:0] code_nibs [$];
	stim_row_t dir_table [24];
	int errors = 0;
	int sent_bytes = 0;
	bit in_quiet = 1'b0;
	bit out_quiet = 1'b0;
	int stall_left = 0;

	subpicture_rle_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .first_byte(first_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_color(pixel_color), .run_length(run_length), .start_column(start_column),
		.line_index(line_index), .line_end(line_end), .field_done(field_done),
		.stream_error(stream_error), .last_of_byte(last_of_byte)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Gap or stall length: mostly none or short, now and then long
	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60)
			return 0;
		if (k < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < MAX_PRINTS)
			$display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Decode one byte into the runs it produces
	function automatic void decode_byte(input logic [7:0] b, input logic first,
			input logic last, output srd_result_t runs [2], output int n);
		int unsigned w, h, rem, len, cnt;
		logic [15:0] v;
		logic [3:0] nib;
		w = (lw_reg > MAX_W) ? MAX_W : lw_reg;
		h = (fl_reg > MAX_L) ? MAX_L : fl_reg;
		runs[0] = '0;
		runs[1] = '0;
		n = 0;
		if (first) begin
			dec_acc = '0;
			dec_held = 0;
			dec_col = 0;
			dec_line = 0;
			dec_halted = 1'b0;
		end
		if (dec_halted)
			return;
		for (int i = 0; i < 2 && !dec_halted; i++) begin
			nib = (i == 0) ? b[7:4] : b[3:0];
			v = {dec_acc[11:0], nib};
			cnt = dec_held + 1;
			// grow the code while it stays below the threshold for its length
			if ((cnt == 1 && v < CODE_LIM_1) || (cnt == 2 && v < CODE_LIM_2) ||
					(cnt == 3 && v < CODE_LIM_3)) begin
				dec_acc = v;
				dec_held = cnt;
				continue;
			end
			dec_acc = '0;
			dec_held = 0;
			rem = (dec_col < w) ? w - dec_col : 0;
			len = (cnt == 4 && v < CODE_LIM_1) ? rem : (v >> 2);
			if (len > rem)
				len = rem;
			runs[n].pixel_color = v[1:0];
			runs[n].run_length = len[12:0];
			runs[n].start_column = dec_col[11:0];
			runs[n].line_index = dec_line[10:0];
			dec_col += len;
			if (dec_col >= w) begin
				runs[n].line_end = 1'b1;
				if (dec_line + 1 >= h) begin
					runs[n].field_done = 1'b1;
					dec_halted = 1'b1;
				end else begin
					dec_line++;
					dec_col = 0;
				end
			end
			n++;
			// drop the rest of the byte at a line end
			if (runs[n-1].line_end)
				break;
		end
		if (last && !dec_halted) begin
			if (n == 0) begin
				runs[0].start_column = dec_col[11:0];
				runs[0].line_index = dec_line[10:0];
				runs[0].stream_error = 1'b1;
				n = 1;
			end else begin
				runs[n-1].stream_error = 1'b1;
			end
			dec_halted = 1'b1;
		end
		if (n > 0)
			runs[n-1].last_of_byte = 1'b1;
	endfunction

	// Predict at each accepted input beat, check each accepted output beat
	always @(posedge clk) begin : track_beats
		srd_result_t runs [2];
		srd_result_t got, want;
		int n;
		if (arst_n && in_valid && !in_stall) begin
			sent_bytes++;
			decode_byte(data_byte, first_byte, last_byte, runs, n);
			case (pin_kind)
				ROW_RUN: runs_due.push_back(pin_run);
				ROW_NONE: ;
				default: begin
					for (int i = 0; i < n; i++)
						runs_due.push_back(runs[i]);
				end
			endcase
		end
		if (arst_n && out_valid && !out_stall) begin
			got = '{pixel_color, run_length, start_column, line_index, line_end,
				field_done, stream_error, last_of_byte};
			if (runs_due.size() == 0) begin
				report_mismatch("run with none pending", 1, 0);
			end else begin
				want = runs_due.pop_front();
				if (got.pixel_color != want.pixel_color)
					report_mismatch("pixel_color", got.pixel_color, want.pixel_color);
				if (got.run_length != want.run_length)
					report_mismatch("run_length", got.run_length, want.run_length);
				if (got.start_column != want.start_column)
					report_mismatch("start_column", got.start_column, want.start_column);
				if (got.line_index != want.line_index)
					report_mismatch("line_index", got.line_index, want.line_index);
				if (got.line_end != want.line_end)
					report_mismatch("line_end", got.line_end, want.line_end);
				if (got.field_done != want.field_done)
					report_mismatch("field_done", got.field_done, want.field_done);
				if (got.stream_error != want.stream_error)
					report_mismatch("stream_error", got.stream_error, want.stream_error);
				if (got.last_of_byte != want.last_of_byte)
					report_mismatch("last_of_byte", got.last_of_byte, want.last_of_byte);
			end
		end
	end

	// Stall the output side in random spans
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
		end else if (out_quiet) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 2) == 0);
			stall_left = pick_gap();
		end
	end

	// Offer one beat after a random gap and hold it until taken
	task automatic send_byte(input logic [7:0] b, input logic f, input logic l,
			input row_kind_t kind, input srd_result_t run);
		int gap;
		bit took;
		gap = in_quiet ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		first_byte <= f;
		last_byte <= l;
		pin_kind <= kind;
		pin_run <= run;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
	endtask

	// Append one well-formed code of random size and content
	function automatic void push_code();
		int k, nn;
		logic [15:0] v;
		k = $urandom_range(0, 99);
		if (k < 30) begin
			v = 16'($urandom_range(4, 15));
			nn = 1;
		end else if (k < 55) begin
			v = 16'($urandom_range('h10, 'h3f));
			nn = 2;
		end else if (k < 75) begin
			v = 16'($urandom_range('h40, 'hff));
			nn = 3;
		end else if (k < 88) begin
			v = 16'($urandom_range('h100, 'h3ff));
			nn = 4;
		end else begin
			v = 16'($urandom_range(0, 3));
			nn = 4;
		end
		for (int s = nn - 1; s >= 0; s--)
			code_nibs.push_back(v[4*s +: 4]);
	endfunction

	// One buffer: mostly coded streams, some raw noise
	task automatic send_buffer();
		int nbytes;
		bit noisy;
		logic [7:0] b;
		noisy = ($urandom_range(0, 99) < 15);
		nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
		code_nibs.delete();
		for (int j = 0; j < nbytes; j++) begin
			if (noisy) begin
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
					$urandom_range(0, 9) == 0, ROW_PREDICT, NO_RUN);
			end else begin
				while (code_nibs.size() < 2)
					push_code();
				b[7:4] = code_nibs.pop_front();
				b[3:0] = code_nibs.pop_front();
				send_byte(b, j == 0, (j == nbytes - 1) && ($urandom_range(0, 9) != 0),
					ROW_PREDICT, NO_RUN);
			end
		end
	endtask

	// Hold output open until every run is back, then let the byte queue empty
	task automatic drain_idle();
		out_quiet = 1'b1;
		while (runs_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		out_quiet = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		if (idx == CFG_LINE_WIDTH)
			lw_reg = val[LINE_WIDTH_W-1:0];
		else
			fl_reg = val[FIELD_LINES_W-1:0];
		@(posedge clk);
	endtask

	initial begin : stimulus
		int phase_w [N_PHASES];
		int phase_h [N_PHASES];
		phase_w = '{LINE_WIDTH_RST, 0, 8191, 4096, 1, 37, 3, 25, 16, 0, 0};
		phase_h = '{FIELD_LINES_RST, 4, 3, 2, 0, 4095, 'h1005, 1, 6, 0, 0};
		phase_w[9] = $urandom_range(2, 64);
		phase_h[9] = $urandom_range(1, 8);
		phase_w[10] = $urandom_range(65, 800);
		phase_h[10] = $urandom_range(2, 12);

		// reset-state rows; typed runs where they are obvious
		dir_table = '{
			'{8'h00, 1'b1, 1'b1, ROW_RUN, ERR_AT_ORIGIN},    // partial code then end
			'{8'h55, 1'b0, 1'b0, ROW_NONE, NO_RUN},          // halted
			'{8'h55, 1'b0, 1'b1, ROW_NONE, NO_RUN},          // halted ignores end
			'{8'h40, 1'b1, 1'b0, ROW_RUN, ONE_PIXEL},        // restart, one pixel
			'{8'h4f, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},       // three-nibble code
			'{8'hff, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},       // two one-nibble codes
			'{8'h10, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},       // two-nibble code
			'{8'h01, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},       // four-nibble code
			'{8'h23, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},
			'{8'h03, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},       // longest plain run
			'{8'hff, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},
			'{8'h40, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},       // fill on a high nibble
			'{8'h00, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},
			'{8'h02, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},       // low nibble dropped
			'{8'h00, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},
			'{8'h07, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},
			'{8'h00, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},       // fill in colour 3
			'{8'h03, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},
			'{8'hf3, 1'b0, 1'b1, ROW_PREDICT, NO_RUN},       // end with partial code
			'{8'h00, 1'b1, 1'b0, ROW_PREDICT, NO_RUN},
			'{8'h0c, 1'b0, 1'b1, ROW_PREDICT, NO_RUN},
			'{8'h12, 1'b1, 1'b1, ROW_PREDICT, NO_RUN},
			'{8'h00, 1'b0, 1'b0, ROW_PREDICT, NO_RUN},
			'{8'hff, 1'b1, 1'b1, ROW_PREDICT, NO_RUN}        // error on second run
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i])
			send_byte(dir_table[i].data, dir_table[i].first, dir_table[i].last,
				dir_table[i].kind, dir_table[i].run);
		in_valid <= 1'b0;
		drain_idle();

		for (int p = 0; p < N_PHASES; p++) begin
			if (p != 0) begin
				write_reg(CFG_LINE_WIDTH, phase_w[p]);
				write_reg(CFG_FIELD_LINES, phase_h[p]);
				cfg_wr_en <= 1'b0;
				// carry the open line across the new setting
				send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, ROW_PREDICT, NO_RUN);
			end
			in_quiet = ($urandom_range(0, 3) == 0);
			sent_bytes = 0;
			while (sent_bytes < PHASE_BYTES)
				send_buffer();
			// leave a line open for the next setting
			send_byte(8'hff, 1'b1, 1'b0, ROW_PREDICT, NO_RUN);
			send_byte(8'hff, 1'b0, 1'b0, ROW_PREDICT, NO_RUN);
			in_valid <= 1'b0;
			in_quiet = 1'b0;
			drain_idle();
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && runs_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
